// File: rtl/core/random_range_generator_assert.svh
// Assertion macros for the random range generator.
`ifndef RANDOM_RANGE_GENERATOR_ASSERT_SVH
`define RANDOM_RANGE_GENERATOR_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define RRG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("random_range_generator: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define RRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("random_range_generator: next-cycle check failed");

`endif

// File: rtl/core/rrg_pkg.sv
// Shared constants and types for the random range generator.
package rrg_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = $clog2(DATA_W);
  localparam logic [31:0] LCG_MUL      = 32'd214013;
  localparam logic [31:0] LCG_ADD      = 32'd2531011;
  localparam int unsigned TEMPER_SHIFT = 15;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

// File: rtl/core/rrg_rem_unit.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module rrg_rem_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rrg_pkg::DATA_W-1:0]  dividend,
  input  logic [rrg_pkg::DATA_W-1:0]  divisor,
  output rrg_pkg::rem_status_t        status,
  output logic [rrg_pkg::DATA_W-1:0]  remainder
);
  import rrg_pkg::*;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic              done;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // A zero divisor always subtracts zero, so the remainder comes out as the
  // whole dividend.
  assign shifted = {rem, dvd[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DATA_W - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (run) begin
      rem <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
      dvd <= {dvd[DATA_W-2:0], 1'b0};
    end
  end

  assign status.busy = run;
  assign status.done = done;
  assign remainder   = rem;

endmodule

// File: rtl/core/random_range_generator.sv
// Top level of the random range generator: LCG seed, tempering and bounded draw.
// Each request carries two signed bounds in either order and returns one signed draw that
// lies between them, inclusive. The seed advances by one LCG step per request, is tempered
// by a shifted XOR and is reduced modulo the span by a serial remainder unit that retires
// one bit per cycle; a full 2^32 span uses the tempered value whole. From one input transfer
// to the next possible one, a request latches the bounds, does the LCG multiply and span,
// loads the remainder unit, runs 32 remainder steps and adds the lower bound into the output
// register. The input is stalled for that whole time, and a result waiting on a stalled output
// holds the block until taken. Writing cfg_wdata with cfg_we reloads the running seed;
// reset seeds it with zero.
module random_range_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] bound_a,
  input  logic signed [31:0] bound_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] draw
);
  import rrg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP,
    ST_WAIT,
    ST_FIN
  } state_t;

  state_t              state;
  logic [DATA_W-1:0]   seed;
  logic [DATA_W-1:0]   a_reg;
  logic [DATA_W-1:0]   b_reg;
  logic [DATA_W-1:0]   low;
  logic [DATA_W-1:0]   span;
  logic [DATA_W-1:0]   seed_next;
  logic [DATA_W-1:0]   tempered;
  logic [DATA_W-1:0]   span_ab;
  logic [DATA_W-1:0]   span_ba;
  logic                a_lt_b;
  logic                in_xfer;
  logic                out_free;
  logic                rem_start;
  rem_status_t         rem_st;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   draw_sum;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign rem_start = (state == ST_SETUP);

  assign seed_next = DATA_W'(seed * LCG_MUL) + LCG_ADD;
  assign tempered  = seed ^ (seed >> TEMPER_SHIFT);

  // Both spans in parallel; the signed compare picks one. Zero means 2^32.
  assign a_lt_b  = $signed(a_reg) < $signed(b_reg);
  assign span_ab = b_reg - a_reg + 1'b1;
  assign span_ba = a_reg - b_reg + 1'b1;

  assign draw_sum = low + rem;

  rrg_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (tempered),
    .divisor   (span),
    .status    (rem_st),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          seed  <= seed_next;
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rem_st.done) begin
            if (out_free) begin
              out_valid <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // reload the running seed; writes must arrive only while idle, which the block does not enforce
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_reg <= bound_a;
      b_reg <= bound_b;
    end
    if (state == ST_MUL) begin
      low  <= a_lt_b ? a_reg : b_reg;
      span <= a_lt_b ? span_ab : span_ba;
    end
    if ((state == ST_WAIT && rem_st.done) || state == ST_FIN) begin
      if (out_free) begin
        draw <= draw_sum;
      end
    end
  end

`include "random_range_generator_assert.svh"

  `RRG_ASSERT_NEXT(a_accept_busy, in_xfer, in_stall && state == ST_MUL)
  `RRG_ASSERT_SAME(a_done_in_wait, rem_st.done, state == ST_WAIT)
  `RRG_ASSERT_SAME(a_idle_unit_quiet, state == ST_IDLE, !rem_st.busy && !rem_st.done)
  `RRG_ASSERT_SAME(a_draw_in_range, $rose(out_valid), span == '0 || (draw - low) < span)

endmodule
